// ----- rtl/core/l9u8map_pkg.sv -----
// Shared types, constants and table functions of the Latin-9 to UTF-8 mapper.
// Used by the controller, the datapath and the top level; depends on nothing.
package l9u8map_pkg;

   localparam int PRIVATE_SLOTS = 32;
   localparam int SLOT_IDX_W    = 5;
   localparam int SLOT_DEPTH    = 1 << SLOT_IDX_W;
   localparam int SLOT_CNT_W    = SLOT_IDX_W + 1;
   localparam int CODE_W        = 21;

   localparam logic [SLOT_CNT_W-1:0] SLOT_LIMIT = SLOT_CNT_W'(PRIVATE_SLOTS);
   localparam logic [7:0] PRIV_BASE    = 8'h80;
   localparam logic [7:0] FULL_BYTE    = 8'hBF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT,
      ST_CHECK,
      ST_SCAN
   } ctrl_state_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_UTF8,
      RSP_DIRECT,
      RSP_HIT,
      RSP_NEW
   } rsp_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        load_priv;
      logic        emit;
      logic        scan_start;
      logic        scan_step;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic in_mode;
      logic in_private;
      logic last_utf8;
      logic direct;
      logic slots_empty;
      logic scan_hit;
      logic scan_end;
   } dp_status_type;

   // Code point of a Latin-9 byte in the range 0xA0 to 0xFF.
   function automatic logic [CODE_W-1:0] latin9_code(input logic [7:0] b);
      logic [CODE_W-1:0] c;
      begin
         unique case (b)
            8'hA4:   c = 21'h020AC;
            8'hA6:   c = 21'h00160;
            8'hA8:   c = 21'h00161;
            8'hB4:   c = 21'h0017D;
            8'hB8:   c = 21'h0017E;
            8'hBC:   c = 21'h00152;
            8'hBD:   c = 21'h00153;
            8'hBE:   c = 21'h00178;
            default: c = {13'd0, b};
         endcase
         return c;
      end
   endfunction

   // Reverse lookup of the eight table entries that lie at or above U+0100.
   // Bit 8 of the result flags a match, bits 7:0 give the byte.
   function automatic logic [8:0] latin9_byte(input logic [CODE_W-1:0] c);
      logic [8:0] r;
      begin
         unique case (c)
            21'h020AC: r = {1'b1, 8'hA4};
            21'h00160: r = {1'b1, 8'hA6};
            21'h00161: r = {1'b1, 8'hA8};
            21'h0017D: r = {1'b1, 8'hB4};
            21'h0017E: r = {1'b1, 8'hB8};
            21'h00152: r = {1'b1, 8'hBC};
            21'h00153: r = {1'b1, 8'hBD};
            21'h00178: r = {1'b1, 8'hBE};
            default:   r = 9'd0;
         endcase
         return r;
      end
   endfunction

   // Index of the final byte of the UTF-8 encoding (byte count less one).
   function automatic logic [1:0] utf8_last_idx(input logic [CODE_W-1:0] c);
      logic [1:0] n;
      begin
         if (c < 21'h80)         n = 2'd0;
         else if (c < 21'h800)   n = 2'd1;
         else if (c < 21'h10000) n = 2'd2;
         else                    n = 2'd3;
         return n;
      end
   endfunction

   // Byte k of the UTF-8 encoding whose final byte index is n.
   function automatic logic [7:0] utf8_byte(input logic [CODE_W-1:0] c,
                                            input logic [1:0] n,
                                            input logic [1:0] k);
      logic [7:0] r;
      logic [3:0] sel;
      begin
         sel = {n, k};
         case (sel)
            4'b0000: r = {1'b0, c[6:0]};
            4'b0100: r = {3'b110, c[10:6]};
            4'b1000: r = {4'b1110, c[15:12]};
            4'b1001: r = {2'b10, c[11:6]};
            4'b1100: r = {5'b11110, c[20:18]};
            4'b1101: r = {2'b10, c[17:12]};
            4'b1110: r = {2'b10, c[11:6]};
            default: r = {2'b10, c[5:0]};
         endcase
         return r;
      end
   endfunction

endpackage

// ----- rtl/core/l9u8map_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; depends on no package.
module l9u8map_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/l9u8map_ctrl.sv -----
// Controller state machine of the mapper: sequences fetch, emit and slot scan.
// Depends on l9u8map_pkg for the state, command and status types.
module l9u8map_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  l9u8map_pkg::dp_status_type st,
   output l9u8map_pkg::dp_cmd_type    cmd
);
   import l9u8map_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (st.in_mode) state_in = ST_CHECK;
               else if (st.in_private) state_in = ST_FETCH;
               else state_in = ST_EMIT;
            end
         end
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (st.last_utf8) state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (st.direct || st.slots_empty) state_in = ST_IDLE;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (st.scan_hit || st.scan_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '{default: '0, rsp_sel: RSP_NONE};
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         ST_FETCH: cmd.load_priv = 1'b1;
         ST_EMIT: begin
            cmd.emit    = 1'b1;
            cmd.rsp_sel = RSP_UTF8;
         end
         ST_CHECK: begin
            if (st.direct) cmd.rsp_sel = RSP_DIRECT;
            else if (st.slots_empty) cmd.rsp_sel = RSP_NEW;
            else cmd.scan_start = 1'b1;
         end
         ST_SCAN: begin
            if (st.scan_hit) cmd.rsp_sel = RSP_HIT;
            else if (st.scan_end) cmd.rsp_sel = RSP_NEW;
            else cmd.scan_step = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ----- rtl/core/l9u8map_dp.sv -----
// Datapath of the mapper: code register, UTF-8 byte counter, private slot map
// with its fill count, and the result registers. Depends on l9u8map_pkg and l9u8map_ram.
module l9u8map_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_mode,
   input  logic [7:0]                          req_byte_in,
   input  logic [l9u8map_pkg::CODE_W-1:0]      req_code_point,
   input  l9u8map_pkg::dp_cmd_type             cmd,
   output l9u8map_pkg::dp_status_type          st,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last,
   output logic                                rsp_overflow
);
   import l9u8map_pkg::*;

   logic [CODE_W-1:0]     code_ff, code_in;
   logic [1:0]            k_ff, k_in;
   logic [SLOT_IDX_W-1:0] ptr_ff, ptr_in;
   logic [SLOT_CNT_W-1:0] used_ff, used_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  ovf_ff, ovf_in;

   logic [SLOT_IDX_W-1:0] rd_addr;
   logic [CODE_W-1:0]     rd_data;
   logic                  wr_en;
   logic [1:0]            n_last;
   logic [8:0]            fixed_hit;
   logic [SLOT_CNT_W-1:0] ptr_next;
   logic                  room;

   l9u8map_ram #(
      .WIDTH (CODE_W),
      .DEPTH (SLOT_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (used_ff[SLOT_IDX_W-1:0]),
      .wr_data (code_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign n_last    = utf8_last_idx(code_ff);
   assign fixed_hit = latin9_byte(code_ff);
   assign ptr_next  = {1'b0, ptr_ff} + SLOT_CNT_W'(1);
   assign room      = used_ff < SLOT_LIMIT;
   assign wr_en     = (cmd.rsp_sel == RSP_NEW) && room;

   always_comb begin
      if (cmd.load_req) rd_addr = req_byte_in[SLOT_IDX_W-1:0];
      else if (cmd.scan_step) rd_addr = ptr_next[SLOT_IDX_W-1:0];
      else rd_addr = '0;
   end

   always_comb begin
      st.in_mode     = req_mode;
      st.in_private  = req_byte_in[7:5] == 3'b100;
      st.last_utf8   = k_ff == n_last;
      st.direct      = (code_ff < 21'h100) || fixed_hit[8];
      st.slots_empty = used_ff == '0;
      st.scan_hit    = rd_data == code_ff;
      st.scan_end    = ptr_next == used_ff;
   end

   always_comb begin
      code_in = code_ff;
      k_in    = k_ff;
      ptr_in  = ptr_ff;
      used_in = used_ff;
      if (cmd.load_req) begin
         k_in   = '0;
         ptr_in = req_byte_in[SLOT_IDX_W-1:0];
         if (req_mode) code_in = req_code_point;
         else if (!req_byte_in[7]) code_in = {13'd0, req_byte_in};
         else if (req_byte_in[7:5] == 3'b100) code_in = '0;
         else code_in = latin9_code(req_byte_in);
      end
      if (cmd.load_priv) begin
         // A slot at or beyond the fill count holds no assigned code and reads as zero.
         code_in = ({1'b0, ptr_ff} < used_ff) ? rd_data : '0;
      end
      if (cmd.emit) k_in = k_ff + 2'd1;
      if (cmd.scan_start) ptr_in = '0;
      if (cmd.scan_step) ptr_in = ptr_next[SLOT_IDX_W-1:0];
      if (wr_en) used_in = used_ff + SLOT_CNT_W'(1);
   end

   always_comb begin
      valid_in = cmd.rsp_sel != RSP_NONE;
      byte_in  = byte_ff;
      last_in  = 1'b1;
      ovf_in   = 1'b0;
      case (cmd.rsp_sel)
         RSP_UTF8: begin
            byte_in = utf8_byte(code_ff, n_last, k_ff);
            last_in = k_ff == n_last;
         end
         RSP_DIRECT: byte_in = fixed_hit[8] ? fixed_hit[7:0] : code_ff[7:0];
         RSP_HIT:    byte_in = PRIV_BASE | {3'd0, ptr_ff};
         RSP_NEW: begin
            if (room) begin
               byte_in = PRIV_BASE | {3'd0, used_ff[SLOT_IDX_W-1:0]};
            end else begin
               byte_in = FULL_BYTE;
               ovf_in  = 1'b1;
            end
         end
         default: byte_in = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         valid_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         used_ff  <= used_in;
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      ptr_ff  <= ptr_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_overflow = ovf_ff;

endmodule

// ----- rtl/core/latin9_utf8_mapper_with_private_slots.sv -----
// Latin-9 to UTF-8 mapper with a 32-slot private code area; one transaction at a time.
// Mode 0: n result bytes (1 to 4), one per cycle, from the emit state; bytes 0x80-0x9F
// first pass through a fetch state that reads the slot RAM.
// Mode 1: one result byte after a check, plus one scan state per filled slot searched.
// Results cannot be stalled. Synchronous reset empties the slot area through its fill count.
module latin9_utf8_mapper_with_private_slots (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [7:0]                     req_byte_in,
   input  logic [l9u8map_pkg::CODE_W-1:0] req_code_point,
   output logic                           rsp_valid,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last,
   output logic                           rsp_overflow
);
   import l9u8map_pkg::*;

   // The controller issues commands; the datapath answers with status only.
   dp_cmd_type    cmd;
   dp_status_type st;

   // The controller sequences each transaction: a fetch of a private slot where the
   // byte needs one, one emit step per UTF-8 byte, or, in mode 1, a direct check
   // followed by a linear search of the filled slots, one slot per cycle.
   l9u8map_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   // The datapath holds the code point, the slot RAM and its fill count, and the
   // registered result. An unknown code point takes the slot at the fill count; when
   // the area is full the result is 0xBF with the overflow flag set.
   l9u8map_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_byte_in    (req_byte_in),
      .req_code_point (req_code_point),
      .cmd            (cmd),
      .st             (st),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ----- tb/latin9_utf8_mapper_with_private_slots_tb.sv -----
// Self-checking testbench for the Latin-9 to UTF-8 mapper with its private slot area.
// Needs l9u8map_pkg and latin9_utf8_mapper_with_private_slots; reads no file.
// Directed rows first, then random traffic, checked by typed bytes or a built-in predictor.
`timescale 1ns / 100ps

module latin9_utf8_mapper_with_private_slots_tb;
   import l9u8map_pkg::*;

   // Mode codes carried on req_mode.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_MAP    = 1'b1;

   localparam int RANDOM_ITEMS  = 286;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 60;

   // One row of stimulus. Where n_typed is non-zero, the row carries its own
   // expected bytes (first byte in typed[0]) and the predictor only tracks state.
   typedef struct packed {
      logic              mode;
      logic [7:0]        byte_in;
      logic [CODE_W-1:0] code_point;
      logic [2:0]        n_typed;
      logic [3:0][7:0]   typed;
   } stim_row_type;

   // One result byte as the receiver should see it.
   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       overflow;
   } out_byte_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_mode;
   logic [7:0]        req_byte_in;
   logic [CODE_W-1:0] req_code_point;
   logic              rsp_valid;
   logic [7:0]        rsp_out_byte;
   logic              rsp_last;
   logic              rsp_overflow;

   // Predictor state: the private slot codes and how many slots are in use.
   logic [CODE_W-1:0] slot_code [SLOT_DEPTH];
   int                slot_fill;

   out_byte_type      awaited_bytes [$];
   stim_row_type      directed_rows [$];
   logic [CODE_W-1:0] issued_codes  [$];
   int                mismatches;
   int                cycle_count;

   latin9_utf8_mapper_with_private_slots dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_byte_in    (req_byte_in),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is cut short here if the mapper ever stops making progress.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("latin9_utf8_mapper_with_private_slots_tb NOT OK");
         $finish;
      end
   end

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // Code point of a Latin-9 byte in the upper half of the table. Only eight
   // positions differ from Latin-1; 0xBE carries the corrected U+0178.
   function automatic logic [CODE_W-1:0] upper_code(input logic [7:0] b);
      logic [CODE_W-1:0] c;
      c = {13'd0, b};
      if (b == 8'hA4) c = 21'h020AC;
      if (b == 8'hA6) c = 21'h00160;
      if (b == 8'hA8) c = 21'h00161;
      if (b == 8'hB4) c = 21'h0017D;
      if (b == 8'hB8) c = 21'h0017E;
      if (b == 8'hBC) c = 21'h00152;
      if (b == 8'hBD) c = 21'h00153;
      if (b == 8'hBE) c = 21'h00178;
      return c;
   endfunction

   // Works out the bytes that one accepted transaction must produce and, if
   // asked, queues them. The slot state is always brought up to date, so that
   // rows with typed-in results keep the predictor in step.
   task automatic convert_item(input logic mode, input logic [7:0] b,
                               input logic [CODE_W-1:0] cp, input bit enqueue);
      logic [CODE_W-1:0] c;
      logic [7:0]        enc [4];
      int                count;
      bit                found;
      out_byte_type      ob;
      count = 0;
      found = 0;
      ob    = '0;
      if (mode == MODE_ENCODE) begin
         if (b < 8'h80) c = {13'd0, b};
         else if (b < 8'hA0) c = slot_code[b[SLOT_IDX_W-1:0]];
         else c = upper_code(b);
         if (c < 21'h80) begin
            enc[0] = {1'b0, c[6:0]};
            count = 1;
         end else if (c < 21'h800) begin
            enc[0] = {3'b110, c[10:6]};
            enc[1] = {2'b10, c[5:0]};
            count = 2;
         end else if (c < 21'h10000) begin
            enc[0] = {4'b1110, c[15:12]};
            enc[1] = {2'b10, c[11:6]};
            enc[2] = {2'b10, c[5:0]};
            count = 3;
         end else begin
            enc[0] = {5'b11110, c[20:18]};
            enc[1] = {2'b10, c[17:12]};
            enc[2] = {2'b10, c[11:6]};
            enc[3] = {2'b10, c[5:0]};
            count = 4;
         end
         for (int k = 0; k < count; k++) begin
            ob.value    = enc[k];
            ob.last     = (k == count - 1);
            ob.overflow = 1'b0;
            if (enqueue) awaited_bytes.push_back(ob);
         end
      end else begin
         ob.last = 1'b1;
         if (cp < 21'h100) begin
            ob.value = cp[7:0];
            found = 1;
         end
         // The private slots are searched ahead of the fixed table.
         for (int i = 0; i < slot_fill && !found; i++) begin
            if (slot_code[i] == cp) begin
               ob.value = PRIV_BASE + 8'(i);
               found = 1;
            end
         end
         for (int k = 0; k < 96 && !found; k++) begin
            if (upper_code(8'hA0 + 8'(k)) == cp) begin
               ob.value = 8'hA0 + 8'(k);
               found = 1;
            end
         end
         if (!found) begin
            if (slot_fill < PRIVATE_SLOTS) begin
               slot_code[slot_fill] = cp;
               ob.value = PRIV_BASE + 8'(slot_fill);
               slot_fill++;
            end else begin
               // Map full: the fallback byte is returned and nothing is stored.
               ob.value    = FULL_BYTE;
               ob.overflow = 1'b1;
            end
         end
         if (enqueue) awaited_bytes.push_back(ob);
      end
   endtask

   // Offers one transaction, possibly after an idle gap, and waits for the
   // edge that accepts it and for busy to fall. Start stays high afterwards, so
   // that a gapless next transaction never sees it dropped and raised in one step.
   task automatic send_item(input stim_row_type r, input bit may_idle);
      int           gap;
      out_byte_type ob;
      gap = 0;
      if (may_idle && $urandom_range(99) < 15) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= r.mode;
      req_byte_in    <= r.byte_in;
      req_code_point <= r.code_point;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.n_typed != 0) begin
         for (int k = 0; k < r.n_typed; k++) begin
            ob.value    = r.typed[k];
            ob.last     = (k == r.n_typed - 1);
            ob.overflow = 1'b0;
            awaited_bytes.push_back(ob);
         end
         convert_item(r.mode, r.byte_in, r.code_point, 1'b0);
      end else begin
         convert_item(r.mode, r.byte_in, r.code_point, 1'b1);
      end
   endtask

   task automatic add_row(input logic mode, input logic [7:0] b,
                          input logic [CODE_W-1:0] cp, input int n,
                          input logic [31:0] bytes);
      stim_row_type r;
      r.mode       = mode;
      r.byte_in    = b;
      r.code_point = cp;
      r.n_typed    = 3'(n);
      r.typed      = bytes;
      directed_rows.push_back(r);
   endtask

   // Every result is taken at the edge that ends its strobe cycle and is
   // compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      out_byte_type ob;
      if (!reset && rsp_valid) begin
         if (awaited_bytes.size() == 0) begin
            note_mismatch($sformatf("result byte %02h with nothing outstanding",
                                    rsp_out_byte));
         end else begin
            ob = awaited_bytes.pop_front();
            if (rsp_out_byte !== ob.value)
               note_mismatch($sformatf("out_byte %02h, predicted %02h",
                                       rsp_out_byte, ob.value));
            if (rsp_last !== ob.last)
               note_mismatch($sformatf("last %b, predicted %b", rsp_last, ob.last));
            if (rsp_overflow !== ob.overflow)
               note_mismatch($sformatf("overflow %b, predicted %b",
                                       rsp_overflow, ob.overflow));
         end
      end
   end

   initial begin
      stim_row_type r;
      int           pick;
      logic [7:0]   special_bytes [8];
      special_bytes = '{8'hA4, 8'hA6, 8'hA8, 8'hB4, 8'hB8, 8'hBC, 8'hBD, 8'hBE};
      mismatches = 0;
      slot_fill  = 0;
      for (int i = 0; i < SLOT_DEPTH; i++) slot_code[i] = '0;

      start          <= 1'b0;
      req_mode       <= MODE_ENCODE;
      req_byte_in    <= '0;
      req_code_point <= '0;
      reset          <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The typed-in bytes are plain UTF-8 of the table entries
      // or the slot indexes handed out in order; a zero count lets the predictor decide.
      add_row(MODE_ENCODE, 8'h00, 21'h000000, 1, 32'h00000000);
      add_row(MODE_ENCODE, 8'h7F, 21'h1FFFFF, 1, 32'h0000007F);
      // Private bytes whose slots have never been assigned encode code zero.
      add_row(MODE_ENCODE, 8'h80, 21'h000000, 1, 32'h00000000);
      add_row(MODE_ENCODE, 8'h9F, 21'h155555, 1, 32'h00000000);
      add_row(MODE_ENCODE, 8'hA0, 21'h000000, 2, 32'h0000A0C2);
      add_row(MODE_ENCODE, 8'hA4, 21'h0AAAAA, 3, 32'h00AC82E2);
      // The corrected entry, U+0178.
      add_row(MODE_ENCODE, 8'hBE, 21'h000000, 2, 32'h0000B8C5);
      add_row(MODE_ENCODE, 8'hFF, 21'h1FFFFF, 2, 32'h0000BFC3);
      add_row(MODE_MAP,    8'hFF, 21'h000000, 1, 32'h00000000);
      add_row(MODE_MAP,    8'h00, 21'h0000FF, 1, 32'h000000FF);
      add_row(MODE_MAP,    8'h55, 21'h0020AC, 1, 32'h000000A4);
      add_row(MODE_MAP,    8'hAA, 21'h000178, 1, 32'h000000BE);
      // Unknown codes take slots in order; the largest code goes first.
      add_row(MODE_MAP,    8'h00, 21'h1FFFFF, 1, 32'h00000080);
      add_row(MODE_ENCODE, 8'h80, 21'h000000, 4, 32'hBFBFBFF7);
      add_row(MODE_MAP,    8'hFF, 21'h000100, 1, 32'h00000081);
      add_row(MODE_MAP,    8'h00, 21'h010000, 1, 32'h00000082);
      add_row(MODE_MAP,    8'h00, 21'h000800, 1, 32'h00000083);
      // A code already held in a slot is found again, not stored twice.
      add_row(MODE_MAP,    8'h00, 21'h1FFFFF, 1, 32'h00000080);
      add_row(MODE_MAP,    8'h00, 21'h00017D, 1, 32'h000000B4);
      add_row(MODE_ENCODE, 8'h81, 21'h1FFFFF, 0, 32'h0);
      add_row(MODE_ENCODE, 8'h82, 21'h000000, 0, 32'h0);
      add_row(MODE_ENCODE, 8'h83, 21'h0AAAAA, 0, 32'h0);
      add_row(MODE_ENCODE, 8'h84, 21'h000000, 1, 32'h00000000);
      add_row(MODE_ENCODE, 8'hA6, 21'h1FFFFF, 0, 32'h0);
      foreach (directed_rows[i]) send_item(directed_rows[i], 1'b1);

      // Random part. Mapping requests mix fresh codes of two to four UTF-8 bytes,
      // repeats of earlier codes, table codes and plain Latin-1 values, so the
      // slot area fills up and then runs into overflow with hits still mixed in.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r            = '0;
         r.mode       = $urandom_range(1) ? MODE_MAP : MODE_ENCODE;
         r.byte_in    = 8'($urandom);
         r.code_point = CODE_W'($urandom);
         if (r.mode == MODE_ENCODE) begin
            pick = $urandom_range(99);
            if (pick < 40) r.byte_in = 8'($urandom_range(8'h80, 8'h9F));
            else if (pick < 60) r.byte_in = 8'($urandom_range(8'hA0, 8'hFF));
            else if (pick < 80) r.byte_in = 8'($urandom_range(8'h7F));
         end else begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               r.code_point = CODE_W'($urandom_range(255));
            end else if (pick < 30) begin
               r.code_point = upper_code(special_bytes[$urandom_range(7)]);
            end else if (pick < 62 && issued_codes.size() != 0) begin
               r.code_point = issued_codes[$urandom_range(issued_codes.size() - 1)];
            end else begin
               pick = $urandom_range(2);
               if (pick == 0) r.code_point = CODE_W'($urandom_range(21'h100, 21'h7FF));
               else if (pick == 1)
                  r.code_point = CODE_W'($urandom_range(21'h800, 21'hFFFF));
               else r.code_point = CODE_W'($urandom_range(21'h10000, 21'h1FFFFF));
               issued_codes.push_back(r.code_point);
            end
         end
         // A long run back to back, with no idle cycles at all.
         send_item(r, !(n >= 120 && n < 200));
      end
      start <= 1'b0;

      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("latin9_utf8_mapper_with_private_slots_tb OK");
      end else begin
         $display("latin9_utf8_mapper_with_private_slots_tb NOT OK");
      end
      $finish;
   end

endmodule
